[rtl/fwcs_pkg.sv]
// Package for the fitness-weighted centroid stepper.
// Holds the request and result types, datapath opcodes, status struct and helpers.
// No dependencies.
package fwcs_pkg;

    localparam int EL_W    = 24;
    localparam int FIT_W   = 32;
    localparam int TOT_W   = 48;
    localparam int CNT_W   = 32;
    localparam int BLEND_W = 17;
    localparam int DVD_W   = 58;
    localparam int DVR_W   = 48;
    localparam int CNT_DIV_W = 6;

    localparam logic [BLEND_W-1:0] BLEND_RESET = 17'd32768;

    typedef struct packed {
        logic                    action;
        logic signed [EL_W-1:0]  element_value;
        logic signed [FIT_W-1:0] point_fitness;
        logic                    last_element;
    } t_in_item;

    typedef struct packed {
        logic                   kind;
        logic signed [EL_W-1:0] coordinate;
        logic                   last_of_run;
        logic                   weight_skipped;
        logic [CNT_W-1:0]       points_absorbed;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_SEED,
        OP_MUL_MEAN,
        OP_DIV_MEAN,
        OP_WR_MEAN,
        OP_MUL_WT,
        OP_DIV_WT,
        OP_WR_WT,
        OP_FIN_NEXT,
        OP_FIN_LAST,
        OP_MUL_A,
        OP_MUL_B,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic is_propose;
        logic seeding;
        logic skip;
        logic last;
        logic div_done;
        logic out_free;
        logic pidx_last;
    } t_dp_stat;

    function automatic logic signed [EL_W-1:0] sat24(input logic signed [59:0] v);
        logic signed [EL_W-1:0] r;
        if (v > 60'sd8388607) begin
            r = 24'sd8388607;
        end else if (v < -60'sd8388608) begin
            r = -24'sd8388608;
        end else begin
            r = v[EL_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/fwcs_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on fwcs_pkg for operand widths.
module fwcs_div import fwcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    logic [DVR_W-1:0]     r_rem;
    logic [DVD_W-1:0]     r_quo;
    logic [DVR_W-1:0]     r_dvr;
    logic [CNT_DIV_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DVR_W:0]       rem_sh;
    logic [DVR_W:0]       rem_sub;

    assign rem_sh  = {r_rem, r_quo[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_DIV_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvr <= i_divisor;
        end else if (r_busy) begin
            // subtract when the shifted remainder covers the divisor
            if (!rem_sub[DVR_W]) begin
                r_rem <= rem_sub[DVR_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DVR_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/fwcs_dp.sv]
// Datapath: centroid memories, count and total, shared multiplier and divider, result register.
// Depends on fwcs_pkg and fwcs_div.
module fwcs_dp import fwcs_pkg::*; #(
    parameter int VECTOR_LENGTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_op             i_op,
    output t_dp_stat           o_stat,
    input  t_in_item           i_in_data,
    input  logic               i_cfg_we,
    input  logic [BLEND_W-1:0] i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data
);

    localparam int IDX_W = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(VECTOR_LENGTH - 1);

    logic signed [EL_W-1:0]  r_mean_mem [VECTOR_LENGTH];
    logic signed [EL_W-1:0]  r_wt_mem   [VECTOR_LENGTH];
    logic [VECTOR_LENGTH-1:0] r_mean_vld;
    logic [VECTOR_LENGTH-1:0] r_wt_vld;

    logic                    r_act;
    logic signed [EL_W-1:0]  r_x;
    logic signed [FIT_W-1:0] r_f;
    logic                    r_last;
    logic [IDX_W-1:0]        r_elem_idx;
    logic [IDX_W-1:0]        r_pidx;
    logic [CNT_W-1:0]        r_count;
    logic signed [TOT_W-1:0] r_total;
    logic [BLEND_W-1:0]      r_blend;
    logic                    r_seed;
    logic [CNT_W-1:0]        r_n;
    logic signed [TOT_W-1:0] r_newt;
    logic signed [EL_W-1:0]  r_rd_m;
    logic signed [EL_W-1:0]  r_rd_w;
    logic signed [DVD_W-1:0] r_prod;
    logic signed [DVD_W-1:0] r_prod2;
    logic                    r_neg;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [IDX_W-1:0]        rd_idx;
    logic signed [TOT_W:0]   tsum;
    logic signed [TOT_W-1:0] tsat;
    logic signed [32:0]      mul_a;
    logic signed [24:0]      mul_b;
    logic signed [DVD_W-1:0] mul_p;
    logic signed [DVD_W-1:0] div_num;
    logic [DVD_W-1:0]        div_an;
    logic [DVR_W-1:0]        div_ad;
    logic [DVD_W-1:0]        div_dvd;
    logic                    div_start;
    logic                    div_done;
    logic [DVD_W-1:0]        div_q;
    logic signed [DVD_W:0]   q_s;
    logic signed [DVD_W-1:0] p_sum;
    logic [DVD_W-1:0]        p_mag;
    logic [DVD_W-1:0]        p_rnd;
    logic signed [DVD_W:0]   p_s;
    logic                    out_free;
    logic                    skip;

    assign rd_idx = r_act ? r_pidx : r_elem_idx;
    assign skip   = !r_seed && (r_newt == '0);

    // saturating fitness total for the incoming point
    assign tsum = {r_total[TOT_W-1], r_total} + {{(TOT_W+1-FIT_W){i_in_data.point_fitness[FIT_W-1]}},
                                                  i_in_data.point_fitness};
    always_comb begin
        if (tsum[TOT_W] != tsum[TOT_W-1]) begin
            tsat = tsum[TOT_W] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}};
        end else begin
            tsat = tsum[TOT_W-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_op)
            OP_MUL_MEAN: begin
                mul_a = $signed({1'b0, r_n - 32'd1});
                mul_b = {r_rd_m[EL_W-1], r_rd_m};
            end
            OP_MUL_WT: begin
                mul_a = {r_f[FIT_W-1], r_f};
                mul_b = {r_x[EL_W-1], r_x} - {r_rd_w[EL_W-1], r_rd_w};
            end
            OP_MUL_A: begin
                mul_a = $signed({16'd0, r_blend});
                mul_b = {r_rd_w[EL_W-1], r_rd_w};
            end
            OP_MUL_B: begin
                mul_a = 33'sd65536 - $signed({16'd0, r_blend});
                mul_b = {r_rd_m[EL_W-1], r_rd_m};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // divider operands: magnitudes, half divisor added for round to nearest
    assign div_num = (i_op == OP_DIV_MEAN)
                   ? r_prod + {{(DVD_W-EL_W){r_x[EL_W-1]}}, r_x} : r_prod;
    assign div_an  = div_num[DVD_W-1] ? DVD_W'(-div_num) : DVD_W'(div_num);
    assign div_ad  = (i_op == OP_DIV_MEAN) ? {{(DVR_W-CNT_W){1'b0}}, r_n}
                   : (r_newt[TOT_W-1] ? DVR_W'(-r_newt) : DVR_W'(r_newt));
    assign div_dvd = div_an + {{(DVD_W-DVR_W+1){1'b0}}, div_ad[DVR_W-1:1]};
    assign div_start = (i_op == OP_DIV_MEAN) || (i_op == OP_DIV_WT);

    fwcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_ad),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign q_s = r_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    // proposal: divide by 65536 with ties away from zero
    assign p_sum = r_prod + r_prod2;
    assign p_mag = p_sum[DVD_W-1] ? DVD_W'(-p_sum) : DVD_W'(p_sum);
    assign p_rnd = (p_mag + DVD_W'(32768)) >> 16;
    assign p_s   = p_sum[DVD_W-1] ? -$signed({1'b0, p_rnd}) : $signed({1'b0, p_rnd});

    assign out_free = !r_out_valid || i_out_ready;

    // centroid memories
    always_ff @(posedge i_clk) begin
        if (i_op == OP_SEED) begin
            r_mean_mem[r_elem_idx] <= r_x;
            r_wt_mem[r_elem_idx]   <= r_x;
        end else if (i_op == OP_WR_MEAN) begin
            r_mean_mem[r_elem_idx] <= sat24({q_s[DVD_W], q_s});
        end else if (i_op == OP_WR_WT) begin
            r_wt_mem[r_elem_idx] <= sat24({q_s[DVD_W], q_s}
                                   + {{(60-EL_W){r_rd_w[EL_W-1]}}, r_rd_w});
        end
        if (i_op == OP_READ) begin
            r_rd_m <= r_mean_vld[rd_idx] ? r_mean_mem[rd_idx] : '0;
            r_rd_w <= r_wt_vld[rd_idx] ? r_wt_mem[rd_idx] : '0;
        end
    end

    // control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean_vld  <= '0;
            r_wt_vld    <= '0;
            r_elem_idx  <= '0;
            r_pidx      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_blend     <= BLEND_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_blend <= i_cfg_data;
            end
            unique case (i_op)
                OP_LOAD: r_pidx <= '0;
                OP_SEED: begin
                    r_mean_vld[r_elem_idx] <= 1'b1;
                    r_wt_vld[r_elem_idx]   <= 1'b1;
                end
                OP_WR_MEAN: r_mean_vld[r_elem_idx] <= 1'b1;
                OP_WR_WT:   r_wt_vld[r_elem_idx]   <= 1'b1;
                OP_FIN_NEXT: begin
                    r_elem_idx <= (r_elem_idx == IDX_LAST) ? '0 : r_elem_idx + 1'b1;
                end
                OP_FIN_LAST: begin
                    r_elem_idx <= '0;
                    r_count    <= r_seed ? CNT_W'(1) : r_n;
                    r_total    <= r_seed ? {{(TOT_W-FIT_W){r_f[FIT_W-1]}}, r_f} : r_newt;
                end
                OP_EMIT: r_pidx <= r_pidx + 1'b1;
                default: ;
            endcase
            if ((i_op == OP_EMIT) || (i_op == OP_FIN_LAST)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture, products and result payload
    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD) begin
            r_act  <= i_in_data.action;
            r_x    <= i_in_data.element_value;
            r_f    <= i_in_data.point_fitness;
            r_last <= i_in_data.last_element;
            r_seed <= (r_count == '0);
            r_n    <= (r_count == '1) ? r_count : r_count + 1'b1;
            r_newt <= tsat;
        end
        if ((i_op == OP_MUL_MEAN) || (i_op == OP_MUL_WT) || (i_op == OP_MUL_A)) begin
            r_prod <= mul_p;
        end
        if (i_op == OP_MUL_B) begin
            r_prod2 <= mul_p;
        end
        if (div_start) begin
            r_neg <= div_num[DVD_W-1] ^ ((i_op == OP_DIV_WT) && r_newt[TOT_W-1]);
        end
        if (i_op == OP_FIN_LAST) begin
            r_out.kind            <= 1'b0;
            r_out.coordinate      <= '0;
            r_out.last_of_run     <= 1'b1;
            r_out.weight_skipped  <= skip;
            r_out.points_absorbed <= r_seed ? CNT_W'(1) : r_n;
        end else if (i_op == OP_EMIT) begin
            r_out.kind            <= 1'b1;
            r_out.coordinate      <= sat24({p_s[DVD_W], p_s});
            r_out.last_of_run     <= (r_pidx == IDX_LAST);
            r_out.weight_skipped  <= 1'b0;
            r_out.points_absorbed <= r_count;
        end
    end

    assign o_stat.is_propose = r_act;
    assign o_stat.seeding    = r_seed;
    assign o_stat.skip       = skip;
    assign o_stat.last       = r_last;
    assign o_stat.div_done   = div_done;
    assign o_stat.out_free   = out_free;
    assign o_stat.pidx_last  = (r_pidx == IDX_LAST);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/fwcs_ctrl.sv]
// Controller: sequences absorb and propose requests through the datapath.
// Depends on fwcs_pkg.
module fwcs_ctrl import fwcs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_READ,
        S_A_SEED,
        S_A_MULM,
        S_A_DIVM,
        S_A_WAITM,
        S_A_WRM,
        S_A_MULW,
        S_A_DIVW,
        S_A_WAITW,
        S_A_WRW,
        S_A_FIN,
        S_P_READ,
        S_P_MULA,
        S_P_MULB,
        S_P_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_A_READ;
                end
            end
            S_A_READ: begin
                // propose requests share the capture cycle, branch here
                if (i_stat.is_propose) begin
                    n_state = S_P_READ;
                end else if (i_stat.seeding) begin
                    n_state = S_A_SEED;
                end else begin
                    o_op    = OP_READ;
                    n_state = S_A_MULM;
                end
            end
            S_A_SEED: begin
                o_op    = OP_SEED;
                n_state = S_A_FIN;
            end
            S_A_MULM: begin
                o_op    = OP_MUL_MEAN;
                n_state = S_A_DIVM;
            end
            S_A_DIVM: begin
                o_op    = OP_DIV_MEAN;
                n_state = S_A_WAITM;
            end
            S_A_WAITM: begin
                if (i_stat.div_done) begin
                    n_state = S_A_WRM;
                end
            end
            S_A_WRM: begin
                o_op    = OP_WR_MEAN;
                n_state = i_stat.skip ? S_A_FIN : S_A_MULW;
            end
            S_A_MULW: begin
                o_op    = OP_MUL_WT;
                n_state = S_A_DIVW;
            end
            S_A_DIVW: begin
                o_op    = OP_DIV_WT;
                n_state = S_A_WAITW;
            end
            S_A_WAITW: begin
                if (i_stat.div_done) begin
                    n_state = S_A_WRW;
                end
            end
            S_A_WRW: begin
                o_op    = OP_WR_WT;
                n_state = S_A_FIN;
            end
            S_A_FIN: begin
                if (!i_stat.last) begin
                    o_op    = OP_FIN_NEXT;
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_op    = OP_FIN_LAST;
                    n_state = S_IDLE;
                end
            end
            S_P_READ: begin
                o_op    = OP_READ;
                n_state = S_P_MULA;
            end
            S_P_MULA: begin
                o_op    = OP_MUL_A;
                n_state = S_P_MULB;
            end
            S_P_MULB: begin
                o_op    = OP_MUL_B;
                n_state = S_P_EMIT;
            end
            S_P_EMIT: begin
                // hold until the result register frees up
                if (i_stat.out_free) begin
                    o_op    = OP_EMIT;
                    n_state = i_stat.pidx_last ? S_IDLE : S_P_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[rtl/fitness_weighted_centroid_step.sv]
// Fitness-weighted centroid stepper, top level.
// Absorb element: when seeding, the value is written into both centroids; otherwise it makes two
// passes through the 58-step restoring divider, the second skipped when the fitness total is zero.
// Propose: read, two multiplies and emit per coordinate, stalling on a full result; one request at a time.
// Synchronous active-low reset clears centroids (valid bits), count and total,
// and sets the blend rate to one half.
module fitness_weighted_centroid_step import fwcs_pkg::*; #(
    parameter int VECTOR_LENGTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_we,
    input  logic [BLEND_W-1:0] i_cfg_data
);

    t_dp_op   op;
    t_dp_stat stat;

    fwcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_op       (op)
    );

    fwcs_dp #(
        .VECTOR_LENGTH (VECTOR_LENGTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
